### rtl/core/rmm_pkg.sv
// Shared types and constants for the running median, mode and mean block.
package rmm_pkg;

   localparam int OP_W     = 3;
   localparam int ITEM_W   = 30;
   localparam int ANS_W    = 30;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_MEAN   = 3'd2;
   localparam logic [OP_W-1:0] OP_MEDIAN = 3'd3;
   localparam logic [OP_W-1:0] OP_MODE   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   localparam int              MOD_W     = 30;
   localparam logic [MOD_W-1:0] MODULUS  = 30'd1000000007;
   localparam logic [MOD_W-1:0] EXPONENT = 30'd1000000005;
   localparam int              EXP_BITS  = 30;
   localparam int              DVD_W     = 64;

   localparam int               MUL_W      = MOD_W + 1;
   localparam int               MUL_P_W    = 2 * MUL_W;
   localparam int               RED_W      = MOD_W + 2;
   localparam logic [MUL_W-1:0] BARRETT_MU =
      MUL_W'(64'h1000_0000_0000_0000 / 64'd1000000007);
   localparam logic [RED_W-1:0] MODULUS_X1 = {2'b00, MODULUS};
   localparam logic [RED_W-1:0] MODULUS_X2 = {1'b0, MODULUS, 1'b0};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ITEM_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [ANS_W-1:0]    answer;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

### rtl/core/running_median_mode_mean.sv
// Top level: sorted multiset with insert, remove, mean, median and mode requests.
//
// Usage: drive req_data and pulse start while busy is low; the request is taken
// at that edge and busy rises. Exactly one response follows: rsp_valid is high
// for a single cycle with rsp_data (answer, status), and busy drops after it.
// Steps from the accepting edge to the response beat, with n stored elements:
//   insert  each larger element shifted up one place, then the new item written
//   remove  a search from the bottom, then each later element shifted down
//   mode    each stored element scanned in turn, in sorted order
//   median  the middle one or two elements read; if inexact, one reduction and the inverse
//   mean    the 64-step divide; if inexact, a reduction and the inverse
// The modular inverse is a 30-step square-and-multiply on one shared 31x31
// multiplier; each modular product is reduced in Barrett steps (quotient estimate,
// multiply by the modulus, subtract, final correction).
// The divide is bit-serial, the exponent is walked bit by bit and the store one element at a time.
// Reset clears count, sum and control; store contents are left as they are.
// The receiver cannot stall: each response beat is taken in its cycle.
module running_median_mode_mean #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 30
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rmm_pkg::req_type req_data,
   output logic            rsp_valid,
   output rmm_pkg::rsp_type rsp_data
);
   import rmm_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = VALUE_BITS + CNT_W;
   localparam int MED_W = VALUE_BITS + 1;
   localparam int DK_W  = $clog2(DVD_W);
   localparam int K_W   = $clog2(EXP_BITS);
   localparam logic [DK_W-1:0]  DIV_LAST = DK_W'(DVD_W - 1);
   localparam logic [K_W-1:0]   EXP_LAST = K_W'(EXP_BITS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   typedef enum logic [20:0] {
      S_IDLE    = 21'h000001,
      S_INS_RD  = 21'h000002,
      S_INS_CMP = 21'h000004,
      S_REM_RD  = 21'h000008,
      S_REM_CMP = 21'h000010,
      S_REM_SH  = 21'h000020,
      S_REM_MV  = 21'h000040,
      S_MED_RD  = 21'h000080,
      S_MED_A   = 21'h000100,
      S_MED_B   = 21'h000200,
      S_MODE_RD = 21'h000400,
      S_MODE_CMP= 21'h000800,
      S_DIV     = 21'h001000,
      S_DIV_END = 21'h002000,
      S_RED_Q   = 21'h004000,
      S_RED_M   = 21'h008000,
      S_RED_SUB = 21'h010000,
      S_RED_FIX = 21'h020000,
      S_EXP_MUL = 21'h040000,
      S_EXP_SQ  = 21'h080000,
      S_DONE    = 21'h100000
   } state_type;

   typedef enum logic [2:0] {
      POST_MEAN_Q,
      POST_MEAN_R,
      POST_MED_R,
      POST_EXP_ACC,
      POST_EXP_SQ
   } post_type;

   logic [VALUE_BITS-1:0] mem [CAPACITY];
   logic [VALUE_BITS-1:0] rd_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;

   state_type             state_ff, state_in;
   post_type              post_ff, post_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [ANS_W-1:0]      ans_ff, ans_in;
   logic [STATUS_W-1:0]   st_ff, st_in;
   logic [VALUE_BITS-1:0] hi_ff, hi_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   logic [CNT_W-1:0]      blen_ff, blen_in;
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [MOD_W-1:0]      dsr_ff, dsr_in;
   logic [MOD_W-1:0]      rem_ff, rem_in;
   logic [DK_W-1:0]       dk_ff, dk_in;
   logic [MOD_W-1:0]      acc_ff, acc_in;
   logic [MOD_W-1:0]      base_ff, base_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [MUL_P_W-1:0]    prod_ff, prod_in;
   logic [RED_W-1:0]      red_ff, red_in;

   logic [MOD_W:0]        div_t;
   logic                  div_ge;
   logic [MED_W-1:0]      med_s;
   logic [CNT_W-1:0]      run_new;
   logic                  mode_upd;
   logic [CNT_W-1:0]      idx_inc;
   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;
   logic [MUL_P_W-1:0]    mul_p;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign div_t    = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_ge   = div_t >= {1'b0, dsr_ff};
   assign med_s    = MED_W'(hi_ff) + MED_W'(rd_ff);
   assign idx_inc  = idx_ff + 1'b1;
   assign run_new  = (idx_ff != '0 && rd_ff == hi_ff) ? run_ff + 1'b1 : CNT_W'(1);
   assign mode_upd = run_new > blen_ff;
   assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_comb begin
      state_in  = state_ff;
      post_in   = post_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      ans_in    = ans_ff;
      st_in     = st_ff;
      hi_in     = hi_ff;
      best_in   = best_ff;
      run_in    = run_ff;
      blen_in   = blen_ff;
      dvd_in    = dvd_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      dk_in     = dk_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      k_in      = k_ff;
      prod_in   = prod_ff;
      red_in    = red_ff;
      mul_a     = '0;
      mul_b     = '0;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = val_ff;
      mem_raddr = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in = req_data.item_value[VALUE_BITS-1:0];
               ans_in = '0;
               st_in  = ST_OK;
               case (req_data.op)
                  OP_INSERT: begin
                     if (cnt_ff == CNT_FULL) begin
                        st_in    = ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        idx_in   = cnt_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     idx_in   = '0;
                     state_in = S_REM_RD;
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_DONE;
                     end else if (req_data.op == OP_MEAN) begin
                        dvd_in   = DVD_W'(sum_ff);
                        dsr_in   = MOD_W'(cnt_ff);
                        rem_in   = '0;
                        dk_in    = '0;
                        post_in  = POST_MEAN_Q;
                        state_in = S_DIV;
                     end else if (req_data.op == OP_MEDIAN) begin
                        state_in = S_MED_RD;
                     end else begin
                        idx_in   = '0;
                        blen_in  = '0;
                        run_in   = '0;
                        state_in = S_MODE_RD;
                     end
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               sum_in   = sum_ff + SUM_W'(val_ff);
               state_in = S_DONE;
            end else begin
               mem_raddr = AW'(idx_ff - 1'b1);
               state_in  = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (rd_ff > val_ff) begin
               mem_wdata = rd_ff;
               idx_in    = idx_ff - 1'b1;
               state_in  = S_INS_RD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               sum_in   = sum_ff + SUM_W'(val_ff);
               state_in = S_DONE;
            end
         end
         S_REM_RD: begin
            if (idx_ff == cnt_ff) begin
               st_in    = ST_ABSENT;
               state_in = S_DONE;
            end else begin
               state_in = S_REM_CMP;
            end
         end
         S_REM_CMP: begin
            if (rd_ff == val_ff) begin
               state_in = S_REM_SH;
            end else begin
               idx_in   = idx_inc;
               state_in = S_REM_RD;
            end
         end
         S_REM_SH: begin
            if (idx_inc == cnt_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               sum_in   = sum_ff - SUM_W'(val_ff);
               state_in = S_DONE;
            end else begin
               mem_raddr = idx_inc[AW-1:0];
               state_in  = S_REM_MV;
            end
         end
         S_REM_MV: begin
            mem_we    = 1'b1;
            mem_wdata = rd_ff;
            idx_in    = idx_inc;
            state_in  = S_REM_SH;
         end
         S_MED_RD: begin
            mem_raddr = AW'(cnt_ff >> 1);
            state_in  = S_MED_A;
         end
         S_MED_A: begin
            if (cnt_ff[0]) begin
               ans_in   = ANS_W'(rd_ff);
               state_in = S_DONE;
            end else begin
               hi_in     = rd_ff;
               mem_raddr = AW'((cnt_ff >> 1) - 1'b1);
               state_in  = S_MED_B;
            end
         end
         S_MED_B: begin
            if (!med_s[0]) begin
               ans_in   = ANS_W'(med_s >> 1);
               state_in = S_DONE;
            end else begin
               dvd_in   = DVD_W'(med_s);
               post_in  = POST_MED_R;
               state_in = S_RED_Q;
            end
         end
         S_MODE_RD: begin
            state_in = S_MODE_CMP;
         end
         S_MODE_CMP: begin
            run_in = run_new;
            hi_in  = rd_ff;
            if (mode_upd) begin
               best_in = rd_ff;
               blen_in = run_new;
            end
            idx_in = idx_inc;
            if (idx_inc == cnt_ff) begin
               ans_in   = ANS_W'(mode_upd ? rd_ff : best_ff);
               state_in = S_DONE;
            end else begin
               state_in = S_MODE_RD;
            end
         end
         S_DIV: begin
            rem_in = div_ge ? MOD_W'(div_t - {1'b0, dsr_ff}) : MOD_W'(div_t);
            dvd_in = {dvd_ff[DVD_W-2:0], div_ge};
            dk_in  = dk_ff + 1'b1;
            if (dk_ff == DIV_LAST) begin
               state_in = S_DIV_END;
            end
         end
         S_RED_Q: begin
            mul_a    = dvd_ff[2*MOD_W-1:MOD_W-1];
            mul_b    = BARRETT_MU;
            prod_in  = mul_p;
            state_in = S_RED_M;
         end
         S_RED_M: begin
            mul_a    = prod_ff[MUL_P_W-1:MOD_W+1];
            mul_b    = MUL_W'(MODULUS);
            prod_in  = mul_p;
            state_in = S_RED_SUB;
         end
         S_RED_SUB: begin
            red_in   = dvd_ff[RED_W-1:0] - prod_ff[RED_W-1:0];
            state_in = S_RED_FIX;
         end
         S_RED_FIX: begin
            if (red_ff >= MODULUS_X2) begin
               rem_in = MOD_W'(red_ff - MODULUS_X2);
            end else if (red_ff >= MODULUS_X1) begin
               rem_in = MOD_W'(red_ff - MODULUS_X1);
            end else begin
               rem_in = red_ff[MOD_W-1:0];
            end
            state_in = S_DIV_END;
         end
         S_DIV_END: begin
            case (post_ff)
               POST_MEAN_Q: begin
                  if (rem_ff == '0) begin
                     ans_in   = dvd_ff[ANS_W-1:0];
                     state_in = S_DONE;
                  end else begin
                     dvd_in   = DVD_W'(sum_ff);
                     post_in  = POST_MEAN_R;
                     state_in = S_RED_Q;
                  end
               end
               POST_MEAN_R: begin
                  acc_in   = rem_ff;
                  base_in  = MOD_W'(cnt_ff);
                  k_in     = '0;
                  state_in = S_EXP_MUL;
               end
               POST_MED_R: begin
                  acc_in   = rem_ff;
                  base_in  = MOD_W'(2);
                  k_in     = '0;
                  state_in = S_EXP_MUL;
               end
               POST_EXP_ACC: begin
                  acc_in   = rem_ff;
                  state_in = S_EXP_SQ;
               end
               default: begin
                  base_in = rem_ff;
                  if (k_ff == EXP_LAST) begin
                     ans_in   = ANS_W'(acc_ff);
                     state_in = S_DONE;
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = S_EXP_MUL;
                  end
               end
            endcase
         end
         S_EXP_MUL: begin
            if (EXPONENT[k_ff]) begin
               mul_a    = MUL_W'(acc_ff);
               mul_b    = MUL_W'(base_ff);
               dvd_in   = DVD_W'(mul_p);
               post_in  = POST_EXP_ACC;
               state_in = S_RED_Q;
            end else begin
               state_in = S_EXP_SQ;
            end
         end
         S_EXP_SQ: begin
            mul_a    = MUL_W'(base_ff);
            mul_b    = MUL_W'(base_ff);
            dvd_in   = DVD_W'(mul_p);
            post_in  = POST_EXP_SQ;
            state_in = S_RED_Q;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
      end
      post_ff <= post_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      ans_ff  <= ans_in;
      st_ff   <= st_in;
      hi_ff   <= hi_in;
      best_ff <= best_in;
      run_ff  <= run_in;
      blen_ff <= blen_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      dk_ff   <= dk_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      red_ff  <= red_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_DONE;
   assign rsp_data.answer = ans_ff;
   assign rsp_data.status = st_ff;

endmodule

### rtl/core/rmm_checker.sv
// Port-level checks for the running median block, bound to the top level.
module rmm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input rmm_pkg::rsp_type rsp_data
);
   import rmm_pkg::*;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response beat outside a busy window");

   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without raising busy");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response not a single beat ending the request");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.answer == '0)
      else $error("error response with nonzero answer");

endmodule

bind running_median_mode_mean rmm_checker u_rmm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
